### rtl/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types, codes and helpers for the hex record decoder.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned POS_W   = 10;

  localparam logic [POS_W-1:0]  POS_MAX         = '1;
  localparam logic [BYTE_W-1:0] MAX_COUNT_RESET = 8'd16;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_CSUM_ERR = 3'd2,
    KIND_END      = 3'd3,
    KIND_TOO_LONG = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] byte_count;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [3:0] d;
    d = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

### rtl/hrd_in_if.sv
// ----------------------------------------------------------------------------
// hrd_in_if
// Character channel: one text character word per handshake.
// ----------------------------------------------------------------------------
interface hrd_in_if;
  logic                          valid;
  logic                          ready;
  logic [hrd_pkg::CHAR_W-1:0]    text_char;
  logic                          restart;

  modport source (output valid, output text_char, output restart, input ready);
  modport sink   (input valid, input text_char, input restart, output ready);
endinterface

### rtl/hrd_out_if.sv
// ----------------------------------------------------------------------------
// hrd_out_if
// Result channel: one data byte or record status word per handshake.
// ----------------------------------------------------------------------------
interface hrd_out_if;
  logic                          valid;
  logic                          ready;
  logic [hrd_pkg::KIND_W-1:0]    kind;
  logic [hrd_pkg::BYTE_W-1:0]    data_byte;
  logic [hrd_pkg::ADDR_W-1:0]    byte_address;
  logic [hrd_pkg::BYTE_W-1:0]    byte_count;

  modport source (output valid, output kind, output data_byte, output byte_address,
                  output byte_count, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_address,
                  input byte_count, output ready);
endinterface

### rtl/hrd_core.sv
// ----------------------------------------------------------------------------
// hrd_core
// Line state registers and the per-character decode step.
// ----------------------------------------------------------------------------
module hrd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [hrd_pkg::CHAR_W-1:0]    text_char,
  input  logic                          restart,
  input  logic                          cfg_wr_en,
  input  logic [hrd_pkg::BYTE_W-1:0]    cfg_wr_data,
  output logic                          res_valid,
  output hrd_pkg::result_t              res
);

  logic [hrd_pkg::BYTE_W-1:0] max_count_r;
  logic [hrd_pkg::POS_W-1:0]  pos_r,   pos_nxt;
  logic [hrd_pkg::BYTE_W-1:0] count_r, count_nxt;
  logic [hrd_pkg::ADDR_W-1:0] addr_r,  addr_nxt;
  logic [hrd_pkg::BYTE_W-1:0] type_r,  type_nxt;
  logic [hrd_pkg::BYTE_W-1:0] sum_r,   sum_nxt;
  logic [3:0]                 hn_r,    hn_nxt;
  logic [hrd_pkg::BYTE_W-1:0] idx_r,   idx_nxt;
  logic                       ended_r, ended_nxt;

  logic                       is_lf, is_cr, is_ws, pos_zero, pos_sat;
  logic                       live, char_step, pair_go;
  logic [3:0]                 digit;
  logic [hrd_pkg::BYTE_W-1:0] pair_b;
  logic [hrd_pkg::POS_W-2:0]  k;
  logic [hrd_pkg::POS_W-1:0]  data_lim;

  logic [hrd_pkg::BYTE_W-1:0] p_count, p_type, p_sum, p_idx;
  logic [hrd_pkg::ADDR_W-1:0] p_addr, p_byte_addr;
  logic                       p_emit;

  assign is_lf    = (text_char == hrd_pkg::CH_LF);
  assign is_cr    = (text_char == hrd_pkg::CH_CR);
  assign is_ws    = (text_char == hrd_pkg::CH_SPACE) || (text_char == hrd_pkg::CH_TAB) ||
                    (text_char == hrd_pkg::CH_VT)    || (text_char == hrd_pkg::CH_FF);
  assign pos_zero = (pos_r == '0);
  assign pos_sat  = (pos_r == hrd_pkg::POS_MAX);
  assign live     = take && !(ended_r && !restart);
  assign char_step = live && !is_lf && !is_cr && !(pos_zero && is_ws) && !pos_sat;
  assign pair_go  = live && !pos_zero && !pos_r[0] && !pos_sat && (is_lf || char_step);
  assign digit    = hrd_pkg::hex_digit(text_char);
  assign pair_b   = {hn_r, (is_lf ? 4'h0 : digit)};
  assign k        = pos_r[hrd_pkg::POS_W-1:1] - 1'b1;
  // data pairs run j = k - 4 from 0 up to count (the checksum)
  assign data_lim = {2'b00, count_r} + 10'd4;

  // pair update
  always_comb begin
    p_count     = count_r;
    p_addr      = addr_r;
    p_type      = type_r;
    p_sum       = sum_r;
    p_idx       = idx_r;
    p_emit      = 1'b0;
    p_byte_addr = addr_r + {8'h00, idx_r};
    case (k)
      9'd0: begin
        p_count = pair_b;
        p_sum   = sum_r + pair_b;
      end
      9'd1: begin
        p_addr = {pair_b, addr_r[7:0]};
        p_sum  = sum_r + pair_b;
      end
      9'd2: begin
        p_addr = {addr_r[15:8], pair_b};
        p_sum  = sum_r + pair_b;
      end
      9'd3: begin
        p_type = pair_b;
        p_sum  = sum_r + pair_b;
      end
      default: begin
        if ({1'b0, k} <= data_lim) begin
          p_sum = sum_r + pair_b;
          if (({1'b0, k} != data_lim) && (type_r == '0) && (count_r <= max_count_r)) begin
            p_idx  = idx_r + 1'b1;
            p_emit = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    type_nxt  = type_r;
    sum_nxt   = sum_r;
    hn_nxt    = hn_r;
    idx_nxt   = idx_r;
    ended_nxt = ended_r;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = hrd_pkg::KIND_DATA;

    if (take && restart) begin
      ended_nxt = 1'b0;
    end

    if (pair_go) begin
      count_nxt = p_count;
      addr_nxt  = p_addr;
      type_nxt  = p_type;
      sum_nxt   = p_sum;
      idx_nxt   = p_idx;
    end

    if (char_step) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r[0]) begin
        hn_nxt = digit;
      end
      if (pair_go && p_emit) begin
        res_valid        = 1'b1;
        res.data_byte    = pair_b;
        res.byte_address = p_byte_addr;
      end
    end

    if (live && is_lf) begin
      res_valid = 1'b1;
      if (pos_zero) begin
        ended_nxt = 1'b1;
        res.kind  = hrd_pkg::KIND_END;
      end else begin
        if (type_nxt != '0) begin
          ended_nxt = 1'b1;
          res.kind  = hrd_pkg::KIND_END;
        end else if (count_nxt > max_count_r) begin
          res.kind       = hrd_pkg::KIND_TOO_LONG;
          res.byte_count = count_nxt;
        end else if (sum_nxt == '0) begin
          res.kind       = hrd_pkg::KIND_OK;
          res.byte_count = count_nxt;
        end else begin
          res.kind       = hrd_pkg::KIND_CSUM_ERR;
          res.byte_count = count_nxt;
        end
        pos_nxt   = '0;
        count_nxt = '0;
        addr_nxt  = '0;
        type_nxt  = '0;
        sum_nxt   = '0;
        hn_nxt    = '0;
        idx_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= hrd_pkg::MAX_COUNT_RESET;
      pos_r       <= '0;
      count_r     <= '0;
      addr_r      <= '0;
      type_r      <= '0;
      sum_r       <= '0;
      hn_r        <= '0;
      idx_r       <= '0;
      ended_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_count_r <= cfg_wr_data;
      end
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      type_r  <= type_nxt;
      sum_r   <= sum_nxt;
      hn_r    <= hn_nxt;
      idx_r   <= idx_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### rtl/hrd_out_stage.sv
// ----------------------------------------------------------------------------
// hrd_out_stage
// Result register; frees the input side whenever the slot is empty or drains.
// ----------------------------------------------------------------------------
module hrd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  hrd_pkg::result_t res,
  input  logic             out_ready,
  output logic             load_ok,
  output logic             out_valid,
  output hrd_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  hrd_pkg::result_t res_r;

  assign load_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_ok) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### rtl/hex_record_decoder.sv
// ----------------------------------------------------------------------------
// hex_record_decoder
// Streaming decoder for hex record text, one character per word.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle while in_ch.ready is high. Its
// decode step updates the line state in the same cycle and any result (data
// byte or record status) appears in the output register in the next cycle.
// in_ch.ready drops only while a result sits in the output register and is
// not taken; the output register is the only thing that limits the rate.
module hex_record_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  hrd_in_if.sink                        in_ch,
  hrd_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [hrd_pkg::BYTE_W-1:0]    cfg_wr_data
);

  logic             take;
  logic             load_ok;
  logic             res_valid;
  hrd_pkg::result_t res;
  hrd_pkg::result_t out_res;

  assign in_ch.ready = load_ok;
  assign take        = in_ch.valid && load_ok;

  hrd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .text_char   (in_ch.text_char),
    .restart     (in_ch.restart),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  hrd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .load_ok   (load_ok),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.kind         = out_res.kind;
  assign out_ch.data_byte    = out_res.data_byte;
  assign out_ch.byte_address = out_res.byte_address;
  assign out_ch.byte_count   = out_res.byte_count;

endmodule
